// ===== rtl/cbad_pkg.sv =====
package cbad_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TOFF_W   = 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BOOT_LOAD = 2'd2;

    // backing store: one byte array covering the whole physical map
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // boot rom sits in the hole left by the echo window
    localparam int                BOOT_ROM_BYTES = 256;
    localparam int                BOOT_IDX_W     = $clog2(BOOT_ROM_BYTES);
    localparam logic [ADDR_W-1:0] BOOT_BASE      = 16'hE000;

    // region bounds
    localparam logic [ADDR_W-1:0] ROM_FIXED_END = 16'h3FFF;
    localparam logic [ADDR_W-1:0] VRAM_BASE     = 16'h8000;
    localparam logic [ADDR_W-1:0] TILE_END      = 16'h97FF;
    localparam logic [ADDR_W-1:0] VRAM_END      = 16'h9FFF;
    localparam logic [ADDR_W-1:0] CART_BASE     = 16'hA000;
    localparam logic [ADDR_W-1:0] CART_END      = 16'hBFFF;
    localparam logic [ADDR_W-1:0] ECHO_BASE     = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_END      = 16'hFDFF;
    localparam logic [ADDR_W-1:0] ECHO_SHIFT    = 16'h2000;
    localparam logic [ADDR_W-1:0] SPRITE_END    = 16'hFEFF;

    // register addresses
    localparam logic [ADDR_W-1:0] ADDR_JOYPAD    = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_DIV       = 16'hFF04;
    localparam logic [ADDR_W-1:0] ADDR_TIMA      = 16'hFF05;
    localparam logic [ADDR_W-1:0] ADDR_TMA       = 16'hFF06;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_FLAGS = 16'hFF0F;
    localparam logic [ADDR_W-1:0] ADDR_LCDC      = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_STAT      = 16'hFF41;
    localparam logic [ADDR_W-1:0] ADDR_SCY       = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCX       = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LY        = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_DMA       = 16'hFF46;
    localparam logic [ADDR_W-1:0] ADDR_BGP       = 16'hFF47;
    localparam logic [ADDR_W-1:0] ADDR_OBP0      = 16'hFF48;
    localparam logic [ADDR_W-1:0] ADDR_OBP1      = 16'hFF49;
    localparam logic [ADDR_W-1:0] ADDR_WY        = 16'hFF4A;
    localparam logic [ADDR_W-1:0] ADDR_WX        = 16'hFF4B;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN    = 16'hFFFF;

    // reset-time contents of the fixed rom and cart regions
    localparam logic [DATA_W-1:0] ROM_FILL  = 8'hFF;
    localparam logic [DATA_W-1:0] CART_FILL = 8'h46;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [TOFF_W-1:0] t_toff;

    // reset value of a physical store location
    function automatic t_byte clear_value(input logic [MEM_AW-1:0] a);
        t_byte v;
        v = '0;
        if (a <= ROM_FIXED_END) begin
            v = ROM_FILL;
        end else if (a >= CART_BASE && a <= CART_END) begin
            v = CART_FILL;
        end
        return v;
    endfunction

endpackage

// ===== rtl/cbad_if.sv =====
interface cbad_req_if;
    logic                  valid;
    logic                  ready;
    cbad_pkg::t_cmd        command;
    cbad_pkg::t_addr       address;
    cbad_pkg::t_byte       write_data;
    cbad_pkg::t_byte       current_line;

    modport source (output valid, command, address, write_data, current_line, input ready);
    modport sink   (input valid, command, address, write_data, current_line, output ready);
endinterface

interface cbad_rsp_if;
    logic                  valid;
    logic                  ready;
    cbad_pkg::t_byte       read_data;
    logic                  tile_changed;
    cbad_pkg::t_toff       tile_offset;
    logic                  palette_changed;
    cbad_pkg::t_byte       palette_value;

    modport source (output valid, read_data, tile_changed, tile_offset, palette_changed,
                    palette_value, input ready);
    modport sink   (input valid, read_data, tile_changed, tile_offset, palette_changed,
                    palette_value, output ready);
endinterface

interface cbad_cfg_if;
    logic valid;
    logic ready;
    logic boot_overlay_on;

    modport source (output valid, boot_overlay_on, input ready);
    modport sink   (input valid, boot_overlay_on, output ready);
endinterface

// ===== rtl/console_bus_address_decoder.sv =====
// The store is read at the accept edge, its data registered beside the stage payload, and
// the result register then captures the muxed value.
// A new item is not accepted while one is at the store access or while a result waits to be
// taken; the single-port byte store is read in the accept cycle and its registered data is
// muxed into the result next. Reset: synchronous, active low. The busy and output-valid
// flags, the mapped registers and the boot overlay clear at once; then a clearing pass writes
// every store byte, during which no item is accepted. Configuration writes are taken at all times.
module console_bus_address_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbad_cfg_if.sink   i_cfg,
    cbad_req_if.sink   i_req,
    cbad_rsp_if.source o_rsp
);
    import cbad_pkg::*;

    // control state
    logic                r_clearing;
    logic                n_clearing;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic                r_boot_overlay;
    logic                r_busy;
    logic                r_out_valid;

    // architectural registers
    t_byte r_lcdc, r_stat, r_scy, r_scx, r_bgp, r_irq_flags, r_irq_en;

    // stage after the store access
    logic  r_s1_use_ram;
    t_byte r_s1_data;
    logic  r_s1_tile;
    t_toff r_s1_toff;
    logic  r_s1_pal;

    // output register
    t_byte r_rd;
    logic  r_tile;
    t_toff r_toff;
    logic  r_pal_chg;
    t_byte r_pal_val;

    // decode results
    logic              acc;
    logic              boot_hit;
    logic [MEM_AW-1:0] boot_phys;
    logic              d_use_ram;
    logic              d_we;
    logic [MEM_AW-1:0] d_phys;
    t_byte             d_data;
    logic              d_tile;
    logic              d_pal;
    logic              d_reg_wr;

    // store port
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    t_byte             mem_wdata;
    t_byte             mem_rdata;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_clearing && !r_busy && (!r_out_valid || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;

    assign boot_hit  = r_boot_overlay && (i_req.address < ADDR_W'(BOOT_ROM_BYTES));
    assign boot_phys = BOOT_BASE | MEM_AW'(i_req.address[BOOT_IDX_W-1:0]);

    // address decode
    always_comb begin
        d_use_ram = 1'b0;
        d_we      = 1'b0;
        d_data    = '0;
        d_tile    = 1'b0;
        d_pal     = 1'b0;
        d_reg_wr  = 1'b0;
        d_phys    = i_req.address;
        if (i_req.address inside {[ECHO_BASE:ECHO_END]}) begin
            d_phys = i_req.address - ECHO_SHIFT;
        end
        case (i_req.command)
            CMD_READ: begin
                if (boot_hit) begin
                    d_use_ram = 1'b1;
                    d_phys    = boot_phys;
                end else if (i_req.address <= SPRITE_END) begin
                    d_use_ram = 1'b1;
                end else begin
                    case (i_req.address)
                        ADDR_JOYPAD, ADDR_DIV, ADDR_TIMA, ADDR_TMA: d_data = '0;
                        ADDR_IRQ_FLAGS: d_data = r_irq_flags;
                        ADDR_LCDC:      d_data = r_lcdc;
                        ADDR_STAT:      d_data = r_stat;
                        ADDR_SCY:       d_data = r_scy;
                        ADDR_SCX:       d_data = r_scx;
                        ADDR_LY:        d_data = i_req.current_line;
                        ADDR_IRQ_EN:    d_data = r_irq_en;
                        default:        d_use_ram = 1'b1;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (boot_hit) begin
                    d_data = '0;
                end else if (i_req.address <= SPRITE_END) begin
                    d_we = 1'b1;
                    if (i_req.address inside {[VRAM_BASE:VRAM_END]}) begin
                        d_tile = (i_req.address <= TILE_END);
                    end else begin
                        d_data = i_req.write_data;
                    end
                end else begin
                    case (i_req.address)
                        ADDR_JOYPAD, ADDR_DIV, ADDR_TIMA, ADDR_TMA, ADDR_DMA,
                        ADDR_OBP0, ADDR_OBP1, ADDR_WY, ADDR_WX: d_data = '0;
                        ADDR_IRQ_FLAGS, ADDR_LCDC, ADDR_STAT, ADDR_SCY, ADDR_SCX,
                        ADDR_IRQ_EN: begin
                            d_reg_wr = 1'b1;
                            d_data   = i_req.write_data;
                        end
                        ADDR_BGP: begin
                            d_reg_wr = 1'b1;
                            d_pal    = 1'b1;
                            d_data   = i_req.write_data;
                        end
                        default: begin
                            d_we   = 1'b1;
                            d_data = i_req.write_data;
                        end
                    endcase
                end
            end
            CMD_BOOT_LOAD: begin
                d_we   = 1'b1;
                d_phys = boot_phys;
            end
            default: d_data = '0;
        endcase
    end

    // store port: clearing pass owns it after reset
    assign mem_we    = r_clearing || (acc && d_we);
    assign mem_addr  = r_clearing ? r_clr_addr : d_phys;
    assign mem_wdata = r_clearing ? clear_value(r_clr_addr) : i_req.write_data;

    cbad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // clearing pass
    assign n_clearing = r_clearing && (r_clr_addr != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_overlay <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_boot_overlay <= i_cfg.boot_overlay_on;
        end
    end

    // mapped registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc      <= '0;
            r_stat      <= '0;
            r_scy       <= '0;
            r_scx       <= '0;
            r_bgp       <= '0;
            r_irq_flags <= '0;
            r_irq_en    <= '0;
        end else if (acc && d_reg_wr) begin
            case (i_req.address)
                ADDR_IRQ_FLAGS: r_irq_flags <= i_req.write_data;
                ADDR_LCDC:      r_lcdc      <= i_req.write_data;
                ADDR_STAT:      r_stat      <= i_req.write_data;
                ADDR_SCY:       r_scy       <= i_req.write_data;
                ADDR_SCX:       r_scx       <= i_req.write_data;
                ADDR_BGP:       r_bgp       <= i_req.write_data;
                ADDR_IRQ_EN:    r_irq_en    <= i_req.write_data;
                default:        r_irq_en    <= r_irq_en;
            endcase
        end
    end

    // item tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= acc;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_use_ram <= d_use_ram;
            r_s1_data    <= d_data;
            r_s1_tile    <= d_tile;
            r_s1_toff    <= d_tile ? i_req.address[TOFF_W-1:0] : '0;
            r_s1_pal     <= d_pal;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rd      <= r_s1_use_ram ? mem_rdata : r_s1_data;
            r_tile    <= r_s1_tile;
            r_toff    <= r_s1_toff;
            r_pal_chg <= r_s1_pal;
            r_pal_val <= r_bgp;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.read_data       = r_rd;
    assign o_rsp.tile_changed    = r_tile;
    assign o_rsp.tile_offset     = r_toff;
    assign o_rsp.palette_changed = r_pal_chg;
    assign o_rsp.palette_value   = r_pal_val;

    // checks
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !acc)
        else $error("item accepted during clearing pass");

    a_result_follows_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("store access did not produce a result");

    a_single_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid && !acc)
        else $error("second item overlaps a pending one");

    a_palette_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && d_pal |=> r_bgp == $past(i_req.write_data))
        else $error("palette write lost");

    a_tile_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_s1_tile |-> !r_s1_use_ram && r_s1_data == '0)
        else $error("tile notification on a non-vram-write item");

endmodule

// ===== rtl/cbad_ram.sv =====
module cbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
